@@ sv/iubr_pkg.sv @@
// ----------------------------------------------------------------------------
// iubr_pkg: shared types and constants for the inverted UART byte receiver
// Holds the phase encoding, result codes and the structs that pass between
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package iubr_pkg;

    localparam int TICK_COUNT_WIDTH = 16;
    localparam int BIT_PERIOD_WIDTH = 16;
    localparam int BYTE_WIDTH       = 8;
    localparam int BIT_INDEX_WIDTH  = 3;
    localparam int CMP_WIDTH        = (TICK_COUNT_WIDTH > BIT_PERIOD_WIDTH) ?
                                      TICK_COUNT_WIDTH : BIT_PERIOD_WIDTH;

    localparam logic [BIT_PERIOD_WIDTH-1:0] BIT_PERIOD_RESET = 16'd104;
    localparam logic [BIT_INDEX_WIDTH-1:0]  LAST_BIT_INDEX   = 3'd7;

    localparam logic ST_BYTE        = 1'b0;
    localparam logic ST_FALSE_START = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_CONFIRM = 5'b00010,
        PH_HALF    = 5'b00100,
        PH_DATA    = 5'b01000,
        PH_STOP    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic valid;
        logic level;
    } t_sample;

    typedef struct packed {
        logic                  valid;
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  status;
    } t_event;

endpackage

@@ sv/iubr_if.sv @@
// ----------------------------------------------------------------------------
// iubr_if: handshake channels of the inverted UART byte receiver
// Sample input, result output and bit period configuration, each with
// valid/ready and its payload.
// ----------------------------------------------------------------------------
interface iubr_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

interface iubr_out_if;
    import iubr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [BYTE_WIDTH-1:0] data_byte;
    logic                  status;

    modport source (output valid, output data_byte, output status, input ready);
    modport sink   (input valid, input data_byte, input status, output ready);
endinterface

interface iubr_cfg_if;
    import iubr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [BIT_PERIOD_WIDTH-1:0] bit_period;

    modport source (output valid, output bit_period, input ready);
    modport sink   (input valid, input bit_period, output ready);
endinterface

@@ sv/inverted_uart_byte_receiver.sv @@
// ----------------------------------------------------------------------------
// inverted_uart_byte_receiver: inverted-polarity 8N1 byte receiver
// Input register, frame sequencer and result register around one line sample
// per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one sampled line level per tick (idle low, start bit high,
//          data bits inverted). One transaction is taken every cycle unless o_out stalls.
//   o_out  delivers a result: data_byte with status 0 for a received byte,
//          or data_byte 0 with status 1 when the start bit fails to confirm.
//   i_cfg  writes bit_period (ticks per bit, reset 104); always ready. Write
//          only while the receiver is idle between frames.
// Path: a sample that ends a frame passes the input register, then the result
//   register, before its result shows on o_out; a stalled o_out can hold the
//   sample in the input register on the way.
// Throughput: one sample per cycle unless o_out stalls; one step per sample.
// Stalls: while o_out holds an untaken result, the held sample waits in the
//   input register and i_in.ready drops until the result is taken; with no
//   result waiting, one transaction is taken every cycle.
// Reset (i_rst_n low at a clock edge): both registers empty, sequencer idle,
//   bit_period back to 104. No clearing pass.
// ----------------------------------------------------------------------------
module inverted_uart_byte_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iubr_in_if.sink     i_in,
    iubr_cfg_if.sink    i_cfg,
    iubr_out_if.source  o_out
);
    import iubr_pkg::*;

    // input register
    logic                        r_in_valid;
    logic                        r_in_level;
    // result register
    logic                        r_out_valid;
    logic [BYTE_WIDTH-1:0]       r_out_byte;
    logic                        r_out_status;
    // configuration
    logic [BIT_PERIOD_WIDTH-1:0] r_bit_period;

    logic    consume;
    t_sample core_sample;
    t_event  core_event;

    // advance the held sample when the result slot is free or draining
    assign consume        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready     = !r_in_valid || consume;
    assign i_cfg.ready    = 1'b1;

    assign core_sample.valid = consume;
    assign core_sample.level = r_in_level;

    iubr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_period (r_bit_period),
        .i_sample     (core_sample),
        .o_event      (core_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RESET;
        end else if (i_cfg.valid) begin
            r_bit_period <= i_cfg.bit_period;
        end
    end

    // input register: load on a transaction, drop when consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_level <= i_in.line_level;
        end
    end

    // result register: load on an event, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_event.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_event.valid) begin
            r_out_byte   <= core_event.data_byte;
            r_out_status <= core_event.status;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.data_byte = r_out_byte;
    assign o_out.status    = r_out_status;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !core_event.valid)
        else $error("result overwritten while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_level)))
        else $error("held sample lost");

    a_false_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FALSE_START) |-> (r_out_byte == '0))
        else $error("false start with nonzero byte");

endmodule

@@ sv/iubr_core.sv @@
// ----------------------------------------------------------------------------
// iubr_core: frame sequencer of the inverted UART byte receiver
// Tracks phase, tick count, bit index and the assembled byte; advances one
// step per sample and flags a byte or false-start event.
// ----------------------------------------------------------------------------
module iubr_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [iubr_pkg::BIT_PERIOD_WIDTH-1:0]   i_bit_period,
    input  iubr_pkg::t_sample                       i_sample,
    output iubr_pkg::t_event                        o_event
);
    import iubr_pkg::*;

    localparam logic [TICK_COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_phase                      r_phase,      n_phase;
    logic [TICK_COUNT_WIDTH-1:0] r_tick_count, n_tick_count;
    logic [BIT_INDEX_WIDTH-1:0]  r_bit_index,  n_bit_index;
    logic [BYTE_WIDTH-1:0]       r_shift_byte, n_shift_byte;

    logic [TICK_COUNT_WIDTH-1:0] tick_inc;
    logic [BIT_PERIOD_WIDTH-1:0] target;
    logic                        wait_done;

    // one wait tick, saturating counter
    always_comb begin
        tick_inc  = (r_tick_count == COUNT_MAX) ? COUNT_MAX
                                                : r_tick_count + TICK_COUNT_WIDTH'(1);
        target    = (r_phase == PH_HALF) ? (i_bit_period >> 1) : i_bit_period;
        wait_done = (CMP_WIDTH'(tick_inc) >= CMP_WIDTH'(target)) || (tick_inc == COUNT_MAX);
    end

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        o_event      = '0;
        if (i_sample.valid) begin
            unique case (r_phase)
                PH_CONFIRM: begin
                    n_tick_count = '0;
                    if (i_sample.level) begin
                        n_phase      = PH_HALF;
                        n_bit_index  = '0;
                        n_shift_byte = '0;
                    end else begin
                        n_phase           = PH_IDLE;
                        o_event.valid     = 1'b1;
                        o_event.data_byte = '0;
                        o_event.status    = ST_FALSE_START;
                    end
                end
                PH_HALF: begin
                    n_tick_count = wait_done ? '0 : tick_inc;
                    if (wait_done) begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_tick_count = wait_done ? '0 : tick_inc;
                    if (wait_done) begin
                        n_shift_byte[r_bit_index] = ~i_sample.level;
                        n_bit_index = r_bit_index + BIT_INDEX_WIDTH'(1);
                        if (r_bit_index == LAST_BIT_INDEX) begin
                            n_phase = PH_STOP;
                        end
                    end
                end
                PH_STOP: begin
                    n_tick_count = wait_done ? '0 : tick_inc;
                    if (wait_done) begin
                        n_phase           = PH_IDLE;
                        o_event.valid     = 1'b1;
                        o_event.data_byte = r_shift_byte;
                        o_event.status    = ST_BYTE;
                    end
                end
                default: begin
                    n_tick_count = '0;
                    n_phase      = i_sample.level ? PH_CONFIRM : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_shift_byte <= '0;
        end else begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
        end
    end

    a_event_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid |-> (r_phase == PH_CONFIRM || r_phase == PH_STOP))
        else $error("event outside confirm or stop phase");

    a_tick_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick_count != '0) |-> (r_phase == PH_HALF || r_phase == PH_DATA ||
                                  r_phase == PH_STOP))
        else $error("tick count running outside a wait");

    a_bit_index_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_index != '0) |-> (r_phase == PH_DATA))
        else $error("bit index set outside data phase");

endmodule

@@ sim/tb_inverted_uart_byte_receiver.sv @@
// ----------------------------------------------------------------------------
// tb_inverted_uart_byte_receiver: self-checking bench for the inverted UART
// byte receiver
// Feeds line samples as framed bytes, false starts and noise at several bit
// periods and handshake pacings. It tracks the frame state per accepted
// sample and compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_inverted_uart_byte_receiver;
    import iubr_pkg::*;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  status;
    } t_rx_result;

    // Handshake pacing of one test phase
    typedef enum int {
        PACE_NONE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } t_pace;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int STALL_PCT     = 72;
    localparam int BOTH_PCT      = 8;
    localparam int PHASE_ITEMS   = 30;
    localparam int PHASE_RESULTS = 3;
    localparam int RANDOM_PHASES = 4;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    iubr_in_if  line_if ();
    iubr_cfg_if cfg_if ();
    iubr_out_if rx_if ();

    inverted_uart_byte_receiver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (line_if),
        .i_cfg   (cfg_if),
        .o_out   (rx_if)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Frame tracker: own copy of the receiver state, advanced per accepted
    // line sample, and the results it expects to come out in order.
    // ------------------------------------------------------------------------
    logic [BIT_PERIOD_WIDTH-1:0] rx_period = BIT_PERIOD_RESET;
    t_phase                      rx_phase  = PH_IDLE;
    logic [TICK_COUNT_WIDTH-1:0] rx_ticks  = '0;
    logic [BIT_INDEX_WIDTH-1:0]  rx_bit    = '0;
    logic [BYTE_WIDTH-1:0]       rx_shift  = '0;
    t_rx_result                  rx_results_q[$];

    // Stimulus side
    logic                        line_q[$];
    logic [BIT_PERIOD_WIDTH-1:0] line_period    = BIT_PERIOD_RESET;
    logic                        line_fire      = 1'b0;
    int unsigned                 pushed_count   = 0;
    int unsigned                 taken_count    = 0;
    int unsigned                 mismatch_count = 0;
    int unsigned                 cycle_count    = 0;
    t_pace                       pace           = PACE_NONE;

    // Count one tick of the current wait; report whether the wait is over.
    // The counter saturates, and a saturated counter ends the wait too.
    function automatic bit tick_wait_over(input longint unsigned target);
        longint unsigned next_count;
        longint unsigned count_top;
        bit              over;
        count_top  = (longint'(1) << TICK_COUNT_WIDTH) - 1;
        next_count = rx_ticks + 1;
        if (next_count > count_top) begin
            next_count = count_top;
        end
        over     = (next_count >= target) || (next_count == count_top);
        rx_ticks = over ? '0 : next_count[TICK_COUNT_WIDTH-1:0];
        return over;
    endfunction

    // Advance the frame state by one line sample and queue any result.
    task automatic decode_line_sample(input logic level);
        case (rx_phase)
            PH_CONFIRM: begin
                if (level) begin
                    rx_phase = PH_HALF;
                    rx_ticks = '0;
                    rx_bit   = '0;
                    rx_shift = '0;
                end else begin
                    // start bit did not hold for a second sample
                    rx_phase = PH_IDLE;
                    rx_ticks = '0;
                    rx_results_q.push_back(t_rx_result'{data_byte: '0,
                                                        status: ST_FALSE_START});
                end
            end
            PH_HALF: begin
                if (tick_wait_over(rx_period >> 1)) begin
                    rx_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (tick_wait_over(rx_period)) begin
                    rx_shift[rx_bit] = ~level;
                    if (rx_bit == LAST_BIT_INDEX) begin
                        rx_bit   = '0;
                        rx_phase = PH_STOP;
                    end else begin
                        rx_bit = rx_bit + 1'b1;
                    end
                end
            end
            PH_STOP: begin
                // stop level is never looked at
                if (tick_wait_over(rx_period)) begin
                    rx_phase = PH_IDLE;
                    rx_results_q.push_back(t_rx_result'{data_byte: rx_shift,
                                                        status: ST_BYTE});
                end
            end
            default: begin
                rx_phase = level ? PH_CONFIRM : PH_IDLE;
                rx_ticks = '0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Pause chance in percent for the sender or the receiver side
    function automatic int pause_pct(input bit receiver_side);
        case (pace)
            PACE_SENDER:   return receiver_side ? 0 : STALL_PCT;
            PACE_RECEIVER: return receiver_side ? STALL_PCT : 0;
            PACE_BOTH:     return BOTH_PCT;
            default:       return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge. Check the result
    // transaction first, then advance the tracker with the accepted sample,
    // so a fresh expectation can never absorb a stray result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rx_result want;
        if (i_rst_n) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_inverted_uart_byte_receiver NOT OK");
                $finish;
            end else begin
                if (rx_if.valid && rx_if.ready) begin
                    if (rx_results_q.size() == 0) begin
                        report_mismatch($sformatf("unexpected result byte %02h status %0d",
                                                  rx_if.data_byte, rx_if.status));
                    end else begin
                        want = rx_results_q.pop_front();
                        if (rx_if.data_byte !== want.data_byte) begin
                            report_mismatch($sformatf("data_byte %02h, expected %02h",
                                                      rx_if.data_byte, want.data_byte));
                        end
                        if (rx_if.status !== want.status) begin
                            report_mismatch($sformatf("status %0d, expected %0d",
                                                      rx_if.status, want.status));
                        end
                    end
                end
                if (cfg_if.valid && cfg_if.ready) begin
                    rx_period = cfg_if.bit_period;
                end
                line_fire = line_if.valid && line_if.ready;
                if (line_fire) begin
                    decode_line_sample(line_if.line_level);
                    taken_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold a sample until its
    // transaction completes, then load the next one or pause at random.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            line_if.valid <= 1'b0;
        end else if (!line_if.valid || line_fire) begin
            if (line_q.size() != 0 && !roll(pause_pct(1'b0))) begin
                line_if.valid      <= 1'b1;
                line_if.line_level <= line_q.pop_front();
            end else begin
                line_if.valid      <= 1'b0;
                line_if.line_level <= 1'($urandom_range(1));
            end
        end
        rx_if.ready <= i_rst_n ? !roll(pause_pct(1'b1)) : 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_level(input logic level);
        line_q.push_back(level);
        pushed_count++;
    endtask

    task automatic push_idle(input int unsigned count);
        repeat (count) push_level(1'b0);
    endtask

    task automatic push_false_start();
        push_level(1'b1);
        push_level(1'b0);
    endtask

    // Build one frame aligned to the receiver's sample points at the current
    // period. With noise on, randomize every sample that is not looked at.
    task automatic push_frame(input logic [BYTE_WIDTH-1:0] value, input bit noisy);
        int unsigned span;
        int unsigned half;
        logic        stop_level;
        span       = (line_period == 0) ? 1 : line_period;
        half       = (line_period < 2) ? 1 : line_period / 2;
        stop_level = 1'($urandom_range(1));
        push_level(1'b1);
        push_level(1'b1);
        repeat (half) push_level(noisy ? 1'($urandom_range(1)) : 1'b1);
        for (int b = 0; b < BYTE_WIDTH; b++) begin
            repeat (span - 1) push_level(noisy ? 1'($urandom_range(1)) : ~value[b]);
            push_level(~value[b]);
        end
        repeat (span) push_level(noisy ? 1'($urandom_range(1)) : stop_level);
    endtask

    // Write the bit period; only called while the receiver is idle.
    task automatic set_period(input logic [BIT_PERIOD_WIDTH-1:0] value);
        @(negedge i_clk);
        cfg_if.bit_period <= value;
        cfg_if.valid      <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        line_period = value;
    endtask

    // Drain the phase: wait for every sample to go in, push low samples until
    // the tracker sits idle, wait for every result, then let the pipe empty.
    task automatic settle();
        while (taken_count != pushed_count) @(negedge i_clk);
        while (rx_phase != PH_IDLE) begin
            push_level(1'b0);
            while (taken_count != pushed_count) @(negedge i_clk);
        end
        while (rx_results_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed frames with random content; the rest false starts,
    // idle gaps and noise bursts that may break a frame mid-way.
    task automatic run_random_phase(input t_pace mode, input logic [BIT_PERIOD_WIDTH-1:0] period);
        int unsigned start_count;
        int unsigned made;
        int unsigned pick;
        set_period(period);
        pace        = mode;
        start_count = pushed_count;
        made        = 0;
        while (pushed_count - start_count < PHASE_ITEMS || made < PHASE_RESULTS) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                push_idle($urandom_range(3));
                push_frame(8'($urandom_range(255)), 1'($urandom_range(1)));
                made++;
            end else if (pick < 75) begin
                push_false_start();
                made++;
            end else if (pick < 88) begin
                push_idle($urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 10)) push_level(1'($urandom_range(1)));
            end
        end
        settle();
        pace = PACE_NONE;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        line_if.valid      = 1'b0;
        line_if.line_level = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.bit_period  = '0;
        rx_if.ready        = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset period: a false start and one full frame
        push_idle(3);
        push_false_start();
        push_frame(8'hA5, 1'b0);
        settle();

        // Longest period, all period bits set: the confirm path does not
        // wait on the period, so a false start still comes out at once
        set_period('1);
        push_false_start();
        settle();

        // Period two: data extremes, single set bits at both ends,
        // back-to-back frames, repeated false starts, noisy frame
        set_period(16'd2);
        push_frame(8'h00, 1'b0);
        push_frame(8'hFF, 1'b0);
        push_frame(8'h01, 1'b0);
        push_frame(8'h80, 1'b0);
        push_false_start();
        push_false_start();
        push_idle(2);
        push_frame(8'h5A, 1'b1);
        settle();

        // Zero and one period (zero has all period bits clear): every wait is one tick
        set_period(16'd0);
        push_frame(8'hAA, 1'b0);
        push_false_start();
        settle();
        set_period(16'd1);
        push_frame(8'h0F, 1'b1);
        settle();

        // Odd period: half wait rounds down
        set_period(16'd3);
        push_frame(8'hC3, 1'b0);
        settle();

        // Random part: rotate through every pacing at short periods
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            run_random_phase(t_pace'(k % 4), 16'($urandom_range(0, 6)));
        end

        if (mismatch_count == 0) begin
            $display("tb_inverted_uart_byte_receiver OK");
        end else begin
            $display("tb_inverted_uart_byte_receiver NOT OK");
        end
        $finish;
    end

endmodule
